// ----- sv/rtcdc_pkg.sv -----
`default_nettype none

package rtcdc_pkg;

  // Fixed-point and counter sizing
  localparam int LOSS_FRAC_BITS = 32;
  localparam int TICK_WIDTH     = 16;
  localparam int TPS_WIDTH      = 16;
  localparam int LOSS_W         = LOSS_FRAC_BITS + 2;
  localparam int SHIFT_UP       = (LOSS_FRAC_BITS >= 32) ? (LOSS_FRAC_BITS - 32) : 0;
  localparam int SHIFT_DN       = (LOSS_FRAC_BITS < 32) ? (32 - LOSS_FRAC_BITS) : 0;
  localparam int TCMP_W         = (TICK_WIDTH > TPS_WIDTH) ? TICK_WIDTH : TPS_WIDTH;

  // One second in accumulator units
  localparam logic signed [LOSS_W-1:0] LOSS_ONE = {2'b01, {LOSS_FRAC_BITS{1'b0}}};

  // Calendar constants
  localparam int SEC_PER_MIN  = 60;
  localparam int HOUR_PER_DAY = 24;
  localparam int MAX_HOUR     = 23;
  localparam int MAX_MIN_SEC  = 59;
  localparam logic signed [33:0] EPOCH_MOD = 34'sd4294967280;

  // Serial remainder unit
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register map
  localparam int PADDR_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC = 2'd2;
  localparam logic [TPS_WIDTH-1:0] TPS_RESET = 16'd64;

  // Item codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;
  localparam logic [1:0] LEAP_NONE = 2'd0;
  localparam logic [1:0] LEAP_INS  = 2'd1;
  localparam logic [1:0] LEAP_REM  = 2'd2;

  typedef struct packed {
    logic       func;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [31:0] epoch_now;
    logic        epoch_half;
    logic        second_boundary;
    logic [1:0]  leap_kind;
    logic        magic_dropped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_ADJ,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic item_load;
    logic div_start;
    logic adjust;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_load;
    logic div_needed;
  } dp_sts_t;

  // Q0.32 drift to accumulator scale; right shift floors
  function automatic logic signed [LOSS_W-1:0] scale_drift(input logic [31:0] v);
    logic signed [63:0] ext;
    logic signed [63:0] sh;
    ext = signed'({{32{v[31]}}, v});
    if (LOSS_FRAC_BITS >= 32) begin
      sh = ext <<< SHIFT_UP;
    end else begin
      sh = ext >>> SHIFT_DN;
    end
    return signed'(sh[LOSS_W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ----- sv/rtcdc_rem.sv -----
`default_nettype none

// Restoring remainder, one dividend bit per cycle
module rtcdc_rem (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      rem
);

  logic                              busy_r, busy_nxt;
  logic [rtcdc_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [31:0]                       rem_r, rem_nxt;
  logic [31:0]                       quo_r, quo_nxt;
  logic [32:0]                       rem_sh;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Shift registers, no reset needed
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // Start load, or one compare-subtract step
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    rem_sh   = {rem_r, quo_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = 32'(rem_sh - {1'b0, divisor});
      end else begin
        rem_nxt = rem_sh[31:0];
      end
      quo_nxt = {quo_r[30:0], 1'b0};
      cnt_nxt = cnt_r + rtcdc_pkg::DIV_CNT_W'(1);
      if (cnt_r == rtcdc_pkg::DIV_CNT_W'(rtcdc_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Last step in flight; rem is final on the next cycle
  assign done = busy_r && (cnt_r == rtcdc_pkg::DIV_CNT_W'(rtcdc_pkg::DIV_STEPS - 1));
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- sv/rtcdc_dp.sv -----
`default_nettype none

module rtcdc_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire rtcdc_pkg::ctrl_cmd_t   cmd,
  output rtcdc_pkg::dp_sts_t          sts,
  input  wire rtcdc_pkg::in_item_t    in_data,
  input  wire logic [15:0]            tps,
  input  wire logic [31:0]            loss_pt,
  input  wire logic [31:0]            magic_iv,
  input  wire logic [31:0]            rem,
  output logic [31:0]                 div_dividend,
  output rtcdc_pkg::out_item_t        out_data
);

  localparam int TW = rtcdc_pkg::TICK_WIDTH;
  localparam int LW = rtcdc_pkg::LOSS_W;

  // Architectural time state
  logic [TW-1:0]         tick_r;
  logic signed [LW-1:0]  loss_r;
  logic [31:0]           epoch_r;
  logic [5:0]            sec_r;
  logic [5:0]            min_r;
  logic [4:0]            hour_r;
  logic                  half_r;

  // Per-beat working registers
  rtcdc_pkg::in_item_t   item_r;
  logic                  bound_r;
  logic [TW-1:0]         tick_w_r;
  logic signed [LW-1:0]  loss_w_r, loss_w_nxt;
  logic [31:0]           e1_r;
  logic signed [33:0]    e2_r, e2_nxt;
  logic signed [6:0]     s2_r, s2_nxt;
  logic [1:0]            leap_r, leap_nxt;
  logic                  magic_r, magic_nxt;
  logic                  div_en_r;
  rtcdc_pkg::out_item_t  out_r;

  logic [TW-1:0]         tick_inc;
  logic                  bound_c;
  logic signed [6:0]     s_base;
  logic signed [6:0]     sec_c;
  logic signed [6:0]     min_c;
  logic signed [5:0]     hour_c;
  logic [5:0]            sec_new;
  logic [5:0]            min_new;
  logic [4:0]            hour_new;
  logic [31:0]           epoch_new;
  logic                  half_new;

  // Tick count and second boundary for the incoming beat
  assign tick_inc = tick_r + TW'(1);
  assign bound_c  = rtcdc_pkg::TCMP_W'(tick_inc) >= rtcdc_pkg::TCMP_W'(tps);

  assign sts.is_load    = (item_r.func == rtcdc_pkg::FUNC_LOAD);
  assign sts.div_needed = bound_r && (magic_iv != '0);
  assign div_dividend   = e1_r;

  // Drift leap decision and second offset
  always_comb begin
    magic_nxt  = div_en_r && (rem == '0);
    s_base     = $signed({1'b0, sec_r}) + $signed({6'd0, bound_r}) - $signed({6'd0, magic_nxt});
    leap_nxt   = rtcdc_pkg::LEAP_NONE;
    s2_nxt     = s_base;
    e2_nxt     = $signed({2'b00, e1_r});
    loss_w_nxt = loss_w_r;
    if (loss_w_r >= rtcdc_pkg::LOSS_ONE) begin
      leap_nxt   = rtcdc_pkg::LEAP_INS;
      s2_nxt     = s_base + 7'sd1;
      e2_nxt     = $signed({2'b00, e1_r}) + 34'sd1;
      loss_w_nxt = loss_w_r - rtcdc_pkg::LOSS_ONE;
    end else if (loss_w_r <= -rtcdc_pkg::LOSS_ONE) begin
      leap_nxt   = rtcdc_pkg::LEAP_REM;
      s2_nxt     = s_base - 7'sd1;
      e2_nxt     = $signed({2'b00, e1_r}) - 34'sd1;
      loss_w_nxt = loss_w_r + rtcdc_pkg::LOSS_ONE;
    end
  end

  // Rollover of seconds, minutes, hours and epoch; a load beat overrides it below
  always_comb begin
    sec_c  = s2_r;
    min_c  = $signed({1'b0, min_r});
    hour_c = $signed({1'b0, hour_r});
    if (s2_r >= 7'(rtcdc_pkg::SEC_PER_MIN)) begin
      sec_c = s2_r - 7'(rtcdc_pkg::SEC_PER_MIN);
      min_c = min_c + 7'sd1;
    end else if (s2_r < 7'sd0) begin
      sec_c = s2_r + 7'(rtcdc_pkg::SEC_PER_MIN);
      min_c = min_c - 7'sd1;
    end
    if (min_c >= 7'(rtcdc_pkg::SEC_PER_MIN)) begin
      min_c  = min_c - 7'(rtcdc_pkg::SEC_PER_MIN);
      hour_c = hour_c + 6'sd1;
    end else if (min_c < 7'sd0) begin
      min_c  = min_c + 7'(rtcdc_pkg::SEC_PER_MIN);
      hour_c = hour_c - 6'sd1;
    end
    if (hour_c >= 6'(rtcdc_pkg::HOUR_PER_DAY)) begin
      hour_c = hour_c - 6'(rtcdc_pkg::HOUR_PER_DAY);
    end else if (hour_c < 6'sd0) begin
      hour_c = hour_c + 6'(rtcdc_pkg::HOUR_PER_DAY);
    end

    half_new  = half_r;
    epoch_new = e2_r[31:0];
    if (e2_r >= rtcdc_pkg::EPOCH_MOD) begin
      epoch_new = 32'(e2_r - rtcdc_pkg::EPOCH_MOD);
      half_new  = ~half_r;
    end else if (e2_r < 34'sd0) begin
      epoch_new = 32'(e2_r + rtcdc_pkg::EPOCH_MOD);
      half_new  = ~half_r;
    end

    sec_new  = sec_c[5:0];
    min_new  = min_c[5:0];
    hour_new = hour_c[4:0];
    // Load beat: clamp to the legal range, epoch untouched
    if (sts.is_load) begin
      hour_new  = (item_r.load_hour > 5'(rtcdc_pkg::MAX_HOUR)) ?
                  5'(rtcdc_pkg::MAX_HOUR) : item_r.load_hour;
      min_new   = (item_r.load_minute > 6'(rtcdc_pkg::MAX_MIN_SEC)) ?
                  6'(rtcdc_pkg::MAX_MIN_SEC) : item_r.load_minute;
      sec_new   = (item_r.load_second > 6'(rtcdc_pkg::MAX_MIN_SEC)) ?
                  6'(rtcdc_pkg::MAX_MIN_SEC) : item_r.load_second;
      epoch_new = epoch_r;
      half_new  = half_r;
    end
  end

  // Time state, updated only on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      loss_r  <= '0;
      epoch_r <= '0;
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= '0;
      half_r  <= 1'b0;
    end else if (cmd.commit) begin
      sec_r  <= sec_new;
      min_r  <= min_new;
      hour_r <= hour_new;
      if (!sts.is_load) begin
        tick_r  <= tick_w_r;
        loss_r  <= loss_w_r;
        epoch_r <= epoch_new;
        half_r  <= half_new;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_r   <= in_data;
      bound_r  <= bound_c;
      tick_w_r <= bound_c ? '0 : tick_inc;
      loss_w_r <= loss_r + rtcdc_pkg::scale_drift(loss_pt);
      e1_r     <= epoch_r + 32'(bound_c);
      div_en_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_en_r <= 1'b1;
    end else if (cmd.adjust) begin
      loss_w_r <= loss_w_nxt;
      e2_r     <= e2_nxt;
      s2_r     <= s2_nxt;
      leap_r   <= leap_nxt;
      magic_r  <= magic_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.hour_now        <= hour_new;
      out_r.minute_now      <= min_new;
      out_r.second_now      <= sec_new;
      out_r.epoch_now       <= epoch_new;
      out_r.epoch_half      <= half_new;
      out_r.second_boundary <= sts.is_load ? 1'b0 : bound_r;
      out_r.leap_kind       <= sts.is_load ? rtcdc_pkg::LEAP_NONE : leap_r;
      out_r.magic_dropped   <= sts.is_load ? 1'b0 : magic_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ----- sv/rtcdc_ctrl.sv -----
`default_nettype none

module rtcdc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire rtcdc_pkg::dp_sts_t   sts,
  input  wire logic                 div_done,
  output rtcdc_pkg::ctrl_cmd_t      cmd
);

  rtcdc_pkg::ctrl_state_t state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtcdc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequencing
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      rtcdc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = rtcdc_pkg::ST_START;
        end
      end
      rtcdc_pkg::ST_START: begin
        if (sts.is_load) begin
          state_nxt = rtcdc_pkg::ST_DONE;
        end else if (sts.div_needed) begin
          cmd.div_start = 1'b1;
          state_nxt     = rtcdc_pkg::ST_DIV;
        end else begin
          state_nxt = rtcdc_pkg::ST_ADJ;
        end
      end
      rtcdc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = rtcdc_pkg::ST_ADJ;
        end
      end
      rtcdc_pkg::ST_ADJ: begin
        cmd.adjust = 1'b1;
        state_nxt  = rtcdc_pkg::ST_DONE;
      end
      rtcdc_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = rtcdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rtcdc_pkg::ST_IDLE;
      end
    endcase
  end

  // Result beat stays until taken
  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);
  assign in_stall      = (state_r != rtcdc_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;

  // Never overwrite a result beat that is still held
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("commit while result beat held");

  // After a start the controller is in the divide state and the remainder unit has not yet raised done
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == rtcdc_pkg::ST_DIV) && !div_done)
    else $error("remainder finished too early");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result beat");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == rtcdc_pkg::ST_START) && in_stall)
    else $error("accepted beat not in progress");

endmodule

`default_nettype wire

// ----- sv/rtc_tick_drift_compensated_core.sv -----
// A load beat goes from accept through the start state to commit. A tick also passes the
// adjust state, and a tick that completes a second with a nonzero magic interval first waits
// on the 32-step serial remainder unit used for the magic interval test. in_stall stays high
// until the commit, so the core takes no new beat while one is in progress.
// A held result beat does not block the next accept, only that beat's commit.
// Reset (rst_n low, synchronous) clears the time state and loads the register defaults.
`default_nettype none

module rtc_tick_drift_compensated_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire rtcdc_pkg::in_item_t                  in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output rtcdc_pkg::out_item_t                      out_data,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rtcdc_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  logic [rtcdc_pkg::TPS_WIDTH-1:0]  tps_r;
  logic [31:0]                      loss_pt_r;
  logic [31:0]                      magic_iv_r;
  logic [rtcdc_pkg::CFG_IDX_W-1:0]  reg_idx;
  logic                             wr_en;

  rtcdc_pkg::ctrl_cmd_t cmd;
  rtcdc_pkg::dp_sts_t   sts;
  logic                 div_done;
  logic [31:0]          rem;
  logic [31:0]          div_dividend;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[rtcdc_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r      <= rtcdc_pkg::TPS_RESET;
      loss_pt_r  <= '0;
      magic_iv_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rtcdc_pkg::REG_TPS:   tps_r      <= pwdata[rtcdc_pkg::TPS_WIDTH-1:0];
        rtcdc_pkg::REG_LOSS:  loss_pt_r  <= pwdata;
        rtcdc_pkg::REG_MAGIC: magic_iv_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      rtcdc_pkg::REG_TPS:   prdata = 32'(tps_r);
      rtcdc_pkg::REG_LOSS:  prdata = loss_pt_r;
      rtcdc_pkg::REG_MAGIC: prdata = magic_iv_r;
      default:              prdata = '0;
    endcase
  end

  rtcdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  rtcdc_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (magic_iv_r),
    .done     (div_done),
    .rem      (rem)
  );

  rtcdc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_data),
    .tps          (tps_r),
    .loss_pt      (loss_pt_r),
    .magic_iv     (magic_iv_r),
    .rem          (rem),
    .div_dividend (div_dividend),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/rtc_time_checker.sv -----
`default_nettype none

module rtc_time_checker
  import rtcdc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire in_item_t             in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire out_item_t            out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  input  wire logic                 pready,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic [TPS_WIDTH-1:0] tps_cfg;
  logic [31:0]          drift_cfg;
  logic [31:0]          magic_cfg;

  // Clock state copies
  longint tick_ctr;
  longint drift_acc;
  longint epoch_sec;
  int     sec_q;
  int     min_q;
  int     hour_q;
  logic   half_q;

  out_item_t expected_times[$];

  initial fail_count = 0;

  // Advance the clock by one beat and return the time it should report
  function automatic out_item_t advance_clock(in_item_t b);
    longint    e;
    longint    one;
    longint    step;
    int        s;
    out_item_t r;
    r = '0;
    r.leap_kind = LEAP_NONE;
    one = longint'(1) << LOSS_FRAC_BITS;
    if (b.func == FUNC_LOAD) begin
      // out-of-range loads clamp to the largest legal value of the field
      hour_q = (b.load_hour > MAX_HOUR) ? MAX_HOUR : int'(b.load_hour);
      min_q  = (b.load_minute > MAX_MIN_SEC) ? MAX_MIN_SEC : int'(b.load_minute);
      sec_q  = (b.load_second > MAX_MIN_SEC) ? MAX_MIN_SEC : int'(b.load_second);
    end else begin
      e = epoch_sec;
      s = sec_q;
      tick_ctr = (tick_ctr + 1) & ((longint'(1) << TICK_WIDTH) - 1);

      // drift in accumulator units, floor on a right shift
      step = longint'($signed(drift_cfg));
      if (LOSS_FRAC_BITS >= 32) begin
        step = step <<< (LOSS_FRAC_BITS - 32);
      end else begin
        step = step >>> (32 - LOSS_FRAC_BITS);
      end
      drift_acc += step;

      // second complete; magic test sees the epoch before any wrap
      if (tick_ctr >= longint'(tps_cfg)) begin
        r.second_boundary = 1'b1;
        e++;
        s++;
        tick_ctr = 0;
        if (magic_cfg != 0 && e > 0 && (e % longint'(magic_cfg)) == 0) begin
          r.magic_dropped = 1'b1;
          s--;
        end
      end

      // leap second from the accumulated drift
      if (drift_acc >= one) begin
        r.leap_kind = LEAP_INS;
        e++;
        s++;
        drift_acc -= one;
      end else if (drift_acc <= -one) begin
        r.leap_kind = LEAP_REM;
        e--;
        s--;
        drift_acc += one;
      end

      // rollover and borrow through the time fields
      if (s >= SEC_PER_MIN) begin
        s -= SEC_PER_MIN;
        min_q++;
      end else if (s < 0) begin
        s += SEC_PER_MIN;
        min_q--;
      end
      if (min_q >= SEC_PER_MIN) begin
        min_q -= SEC_PER_MIN;
        hour_q++;
      end else if (min_q < 0) begin
        min_q += SEC_PER_MIN;
        hour_q--;
      end
      if (hour_q >= HOUR_PER_DAY) begin
        hour_q -= HOUR_PER_DAY;
      end else if (hour_q < 0) begin
        hour_q += HOUR_PER_DAY;
      end
      sec_q = s;

      // epoch wrap in either direction flips the half flag
      if (e >= longint'(EPOCH_MOD)) begin
        e -= longint'(EPOCH_MOD);
        half_q = ~half_q;
      end else if (e < 0) begin
        e += longint'(EPOCH_MOD);
        half_q = ~half_q;
      end
      epoch_sec = e;
    end
    r.hour_now   = hour_q[4:0];
    r.minute_now = min_q[5:0];
    r.second_now = sec_q[5:0];
    r.epoch_now  = epoch_sec[31:0];
    r.epoch_half = half_q;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Watch config writes, input beats and result beats
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      tps_cfg   = TPS_RESET;
      drift_cfg = '0;
      magic_cfg = '0;
      tick_ctr  = 0;
      drift_acc = 0;
      epoch_sec = 0;
      sec_q     = 0;
      min_q     = 0;
      hour_q    = 0;
      half_q    = 1'b0;
      expected_times.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_IDX_W+1:2])
          REG_TPS:   tps_cfg   = pwdata[TPS_WIDTH-1:0];
          REG_LOSS:  drift_cfg = pwdata;
          REG_MAGIC: magic_cfg = pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_times.push_back(advance_clock(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_times.size() == 0) begin
          $error("result beat with no expected time waiting: %p", out_data);
          fail_count++;
        end else begin
          want = expected_times.pop_front();
          check_field("hour_now", want.hour_now, out_data.hour_now);
          check_field("minute_now", want.minute_now, out_data.minute_now);
          check_field("second_now", want.second_now, out_data.second_now);
          check_field("epoch_now", want.epoch_now, out_data.epoch_now);
          check_field("epoch_half", want.epoch_half, out_data.epoch_half);
          check_field("second_boundary", want.second_boundary, out_data.second_boundary);
          check_field("leap_kind", want.leap_kind, out_data.leap_kind);
          check_field("magic_dropped", want.magic_dropped, out_data.magic_dropped);
        end
      end
      pending <= expected_times.size();
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rtcdc_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;

  // idle rates in percent, and the long receiver hold-off request
  int   gap_pct;
  int   stall_pct;
  logic hold_req;

  rtc_tick_drift_compensated_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  rtc_time_checker u_time_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Run limit
  initial begin
    #12_000_000;
    $display("rtc_tick_drift_compensated_core regression: fail");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (300) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic in_item_t mk_tick();
    logic [31:0] r;
    in_item_t    b;
    r = $urandom;
    b = r[$bits(in_item_t)-1:0];
    b.func = FUNC_TICK;
    return b;
  endfunction

  function automatic in_item_t mk_load(int h, int m, int s);
    in_item_t b;
    b.func        = FUNC_LOAD;
    b.load_hour   = h[4:0];
    b.load_minute = m[5:0];
    b.load_second = s[5:0];
    return b;
  endfunction

  // One beat, with random sender gaps ahead of it
  task automatic send_beat(in_item_t b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every expected time, then cover the longest latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_setting(logic [31:0] tps, logic [31:0] loss, logic [31:0] magic);
    wait_idle();
    write_reg(REG_TPS, tps);
    write_reg(REG_LOSS, loss);
    write_reg(REG_MAGIC, magic);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_random_setting();
    logic [31:0] tps;
    logic [31:0] loss;
    logic [31:0] magic;
    case ($urandom_range(0, 5))
      0:       tps = 32'd0;
      1:       tps = 32'hFFFF_FFFF;
      2, 3:    tps = $urandom_range(1, 4);
      4:       tps = $urandom_range(5, 40);
      default: tps = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       loss = 32'd0;
      1:       loss = 32'h8000_0000;
      2:       loss = 32'h7FFF_FFFF;
      3:       loss = $urandom_range(0, 32'h0FFF_FFFF);
      4:       loss = -$urandom_range(0, 32'h0FFF_FFFF);
      default: loss = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       magic = 32'd0;
      1, 2:    magic = $urandom_range(1, 7);
      3:       magic = 32'd4294967280;
      4:       magic = 32'hFFFF_FFFF;
      default: magic = $urandom;
    endcase
    apply_setting(tps, loss, magic);
  endtask

  task automatic send_random_beat();
    if ($urandom_range(0, 99) < 12) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(mk_load($urandom_range(0, 31), $urandom_range(0, 63),
                          $urandom_range(0, 63)));
      end else begin
        send_beat(mk_load($urandom_range(0, MAX_HOUR), $urandom_range(0, MAX_MIN_SEC),
                          $urandom_range(0, MAX_MIN_SEC)));
      end
    end else begin
      send_beat(mk_tick());
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // day rollover, clamped loads, field minimums
    apply_setting(32'd1, 32'd0, 32'd0);
    send_beat(mk_load(MAX_HOUR, MAX_MIN_SEC, MAX_MIN_SEC));
    send_beat(mk_tick());
    send_beat(mk_load(31, 63, 63));
    send_beat(mk_load(0, 0, 0));
    send_beat(mk_tick());
    send_beat(mk_tick());

    // zero ticks per second
    apply_setting(32'd0, 32'd0, 32'd0);
    send_beat(mk_tick());
    send_beat(mk_tick());

    // removal at 00:00:00 borrows back through every field to 23:59:59
    apply_setting(32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
    send_beat(mk_load(0, 0, 0));
    send_beat(mk_tick());
    send_beat(mk_tick());

    // magic interval equal to the epoch modulus, one tick
    apply_setting(32'd1, 32'd0, 32'd4294967280);
    send_beat(mk_tick());

    // every second dropped while drift inserts
    apply_setting(32'd1, 32'h7FFF_FFFF, 32'd1);
    repeat (4) send_beat(mk_tick());

    // boundary, drop and removal together at second zero
    apply_setting(32'd1, 32'h8000_0000, 32'd1);
    send_beat(mk_load(0, 0, 0));
    repeat (3) send_beat(mk_tick());

    // random phases over the idle modes
    for (int p = 0; p < 8; p++) begin
      gap_pct   = 0;
      stall_pct = 0;
      apply_random_setting();
      case (p % 4)
        1:       gap_pct = 48;
        2:       stall_pct = 48;
        3: begin
          gap_pct   = 31;
          stall_pct = 31;
        end
        default: ;
      endcase
      if (p == 1) hold_req = 1'b1;
      repeat (95) send_random_beat();
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("rtc_tick_drift_compensated_core regression: pass");
    end else begin
      $display("rtc_tick_drift_compensated_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
sv/rtcdc_pkg.sv
sv/rtcdc_rem.sv
sv/rtcdc_dp.sv
sv/rtcdc_ctrl.sv
sv/rtc_tick_drift_compensated_core.sv
tb/rtc_time_checker.sv
tb/tb_top.sv
